[rtl/pesq_pkg.sv]
// pesq_pkg: shared constants, request codes and controller/datapath structs
// for the per-expert sum-of-squares accumulator
// no dependencies
`timescale 1ns / 1ps

package pesq_pkg;

    // default sizes of the store
    localparam int MAX_EXPERTS_DEF = 16;
    localparam int MAX_COLUMNS_DEF = 1024;

    // field widths
    localparam int EXPERT_W = 4;
    localparam int COLUMN_W = 10;
    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 31;
    localparam int SUM_W    = 48;
    localparam int CNT_W    = 32;

    // stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 80;

    // configuration registers
    localparam int NEXP_W     = 5;
    localparam int NCOL_W     = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_EXPERTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLUMNS = 1'b1;

    localparam logic [NEXP_W-1:0] NUM_EXPERTS_RST = 5'd16;
    localparam logic [NCOL_W-1:0] NUM_COLUMNS_RST = 11'd1024;

    // request kinds carried on s_tuser
    localparam logic REQ_ACCUMULATE = 1'b0;
    localparam logic REQ_READOUT    = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic take;
        logic rd_en;
        logic acc_wr;
        logic div_start;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic is_readout;
        logic need_div;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/per_expert_sum_of_squares_accumulator.sv]
// accumulate item: accept, store read, then update and write back
// readout: accept, store read, the 48-step divide when dividing, then the result is
//   registered once the output is free; no divide when the cell is out of range
//   or the expert has no rows; single store port, next item taken only when done
// reset: synchronous active-low; a clearing sweep over all MAX_EXPERTS*MAX_COLUMNS
//   cells (16384 by default) zeroes the sum store, s_tready stays low meanwhile
`timescale 1ns / 1ps

module per_expert_sum_of_squares_accumulator
    import pesq_pkg::*;
#(
    parameter int MAX_EXPERTS = MAX_EXPERTS_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // expert[3:0], column[13:4], sample[29:14]
    input  logic                  s_tuser,   // req_type
    input  logic                  s_tlast,   // row_end

    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // mean_square[47:0], row_count[79:48]
    output logic                  m_tuser,   // no_samples

    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // controller sequences the item through read, update or divide;
    // the datapath holds the sum store, row counts and divider
    dp_cmd_t    cmd;
    dp_status_t sts;

    pesq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pesq_dp #(
        .MAX_EXPERTS (MAX_EXPERTS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

[rtl/pesq_ram.sv]
// pesq_ram: generic single-port RAM with registered read
// no dependencies
`timescale 1ns / 1ps

module pesq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pesq_div.sv]
// pesq_div: restoring divider, one quotient bit per cycle
// depends on pesq_pkg
`timescale 1ns / 1ps

module pesq_div
    import pesq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [CNT_W:0]    shifted;
    logic [CNT_W+1:0]  diff;

    // shift one dividend bit into the partial remainder and try the subtract
    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                step_reg <= STEP_W'(SUM_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!diff[CNT_W+1]) begin
                    rem_reg <= diff[CNT_W-1:0];
                    quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted[CNT_W-1:0];
                    quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                end
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/pesq_dp.sv]
// pesq_dp: datapath - item latch, range checks, sum store, row counts,
// squarer, saturating adder, divider and output register
// depends on pesq_pkg, pesq_ram, pesq_div
`timescale 1ns / 1ps

module pesq_dp
    import pesq_pkg::*;
#(
    parameter int MAX_EXPERTS = MAX_EXPERTS_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_status_t            sts,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int DEPTH  = MAX_EXPERTS * MAX_COLUMNS;
    localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CI_W   = MAX_EXPERTS > 1 ? $clog2(MAX_EXPERTS) : 1;

    logic [NEXP_W-1:0]   num_experts_reg;
    logic [NCOL_W-1:0]   num_columns_reg;

    logic                req_reg;
    logic [EXPERT_W-1:0] ex_reg;
    logic [COLUMN_W-1:0] col_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                row_end_reg;
    logic [SQ_W-1:0]     sq_reg;

    logic [CNT_W-1:0]    count_reg [MAX_EXPERTS];
    logic [ADDR_W-1:0]   clr_addr_reg;

    logic                m_tvalid_reg;
    logic [SUM_W-1:0]    mean_reg;
    logic [CNT_W-1:0]    cnt_out_reg;
    logic                no_samples_reg;

    logic                ex_ok;
    logic                col_ok;
    logic                cell_ok;
    logic [CI_W-1:0]     cnt_idx;
    logic [CNT_W-1:0]    cnt_cur;
    logic [ADDR_W-1:0]   cell_addr;
    logic [SAMPLE_W-1:0] mag;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]    rd_data;
    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_addr;
    logic [SUM_W-1:0]    ram_wdata;
    logic                div_done;
    logic [SUM_W-1:0]    quotient;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_experts_reg <= NUM_EXPERTS_RST;
            num_columns_reg <= NUM_COLUMNS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_NUM_EXPERTS: num_experts_reg <= cfg_wdata[NEXP_W-1:0];
                REG_NUM_COLUMNS: num_columns_reg <= cfg_wdata[NCOL_W-1:0];
                default: ;
            endcase
        end
    end

    // item latch; tdata holds expert, column, sample from bit 0 up
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            req_reg     <= s_tuser;
            ex_reg      <= s_tdata[EXPERT_W-1:0];
            col_reg     <= s_tdata[EXPERT_W +: COLUMN_W];
            sample_reg  <= s_tdata[EXPERT_W+COLUMN_W +: SAMPLE_W];
            row_end_reg <= s_tlast;
        end
    end

    // range checks against both the register and the store size
    assign ex_ok   = (ex_reg < num_experts_reg) && (32'(ex_reg) < MAX_EXPERTS);
    assign col_ok  = (col_reg < num_columns_reg) && (32'(col_reg) < MAX_COLUMNS);
    assign cell_ok = ex_ok && col_ok;

    assign cnt_idx   = CI_W'(ex_reg);
    assign cnt_cur   = count_reg[cnt_idx];
    assign cell_addr = ADDR_W'(32'(ex_reg) * 32'(MAX_COLUMNS) + 32'(col_reg));

    // squarer, registered before the add
    assign mag = sample_reg[SAMPLE_W-1] ? SAMPLE_W'(-sample_reg) : sample_reg;

    always_ff @(posedge aclk) begin
        sq_reg <= SQ_W'({{SAMPLE_W{1'b0}}, mag} * {{SAMPLE_W{1'b0}}, mag});
    end

    // saturating accumulate
    assign sum_wide = {1'b0, rd_data} + (SUM_W+1)'(sq_reg);
    assign sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

    // clearing sweep address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_wr) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign ram_we    = cmd.clear_wr || (cmd.acc_wr && cell_ok);
    assign ram_re    = cmd.rd_en && cell_ok;
    assign ram_addr  = cmd.clear_wr ? clr_addr_reg : cell_addr;
    assign ram_wdata = cmd.clear_wr ? '0 : sum_next;

    pesq_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_sums (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rd_data)
    );

    // row counts, saturating
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_EXPERTS; i++) begin
                count_reg[i] <= '0;
            end
        end else if (cmd.acc_wr && ex_ok && row_end_reg && (cnt_cur != '1)) begin
            count_reg[cnt_idx] <= cnt_cur + 1'b1;
        end
    end

    pesq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (rd_data),
        .divisor  (cnt_cur),
        .done     (div_done),
        .quotient (quotient)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (sts.need_div) begin
                mean_reg       <= quotient;
                cnt_out_reg    <= cnt_cur;
                no_samples_reg <= 1'b0;
            end else begin
                mean_reg       <= '0;
                cnt_out_reg    <= '0;
                no_samples_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {cnt_out_reg, mean_reg};
    assign m_tuser  = no_samples_reg;

    assign sts.clear_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign sts.is_readout = (req_reg == REQ_READOUT);
    assign sts.need_div   = cell_ok && (cnt_cur != '0);
    assign sts.div_done   = div_done;
    assign sts.out_free   = !m_tvalid_reg || m_tready;

endmodule

[rtl/pesq_ctrl.sv]
// pesq_ctrl: controller state machine - clearing sweep, item sequencing,
// divide wait and result hand-off
// depends on pesq_pkg
`timescale 1ns / 1ps

module pesq_ctrl
    import pesq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIVIDE,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            ready_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    if (sts.clear_last) begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid && ready_reg) begin
                        state_reg <= S_READ;
                        ready_reg <= 1'b0;
                    end
                end
                S_READ: begin
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    if (!sts.is_readout) begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end else if (sts.need_div) begin
                        state_reg <= S_DIVIDE;
                    end else begin
                        state_reg <= S_FINISH;
                    end
                end
                S_DIVIDE: begin
                    if (sts.div_done) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (sts.out_free) begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= S_CLEAR;
                    ready_reg <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            S_CLEAR:  cmd.clear_wr = 1'b1;
            S_IDLE:   cmd.take = s_tvalid && ready_reg;
            S_READ:   cmd.rd_en = 1'b1;
            S_EXEC: begin
                cmd.acc_wr    = !sts.is_readout;
                cmd.div_start = sts.is_readout && sts.need_div;
            end
            S_FINISH: cmd.out_load = sts.out_free;
            default:  cmd = '0;
        endcase
    end

    assign s_tready = ready_reg;

    // reset always restarts the clearing sweep
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> state_reg == S_CLEAR)
        else $error("reset did not restart the clearing sweep");

    // items are only taken while idle
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> state_reg == S_IDLE)
        else $error("ready raised outside idle");

    // an accepted item goes straight to the store read
    a_accept_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && ready_reg) |=> state_reg == S_READ)
        else $error("accepted item did not start a read");

    // divider only finishes while it is being waited for
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> state_reg == S_DIVIDE)
        else $error("divider finished outside the divide wait");

    // a readout result is loaded only when the output register is free
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free && sts.is_readout)
        else $error("result loaded into a busy output register");

endmodule

[verif/per_expert_sum_of_squares_accumulator_tb.sv]
// self-checking testbench for per_expert_sum_of_squares_accumulator: directed items,
// then random rows of samples and readouts under several expert/column limits
// depends on pesq_pkg and the accumulator rtl only
`timescale 1ns / 1ps

module per_expert_sum_of_squares_accumulator_tb;
    import pesq_pkg::*;

    localparam int N_EXPERTS     = MAX_EXPERTS_DEF;
    localparam int N_COLUMNS     = MAX_COLUMNS_DEF;
    // longer than the longest readout, so this covers any item still in flight
    localparam int SETTLE_CYCLES = 64;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 72;
    localparam int PAD_W         = S_TDATA_W - SAMPLE_W - COLUMN_W - EXPERT_W;

    // one input item as the block sees it
    typedef struct packed {
        logic                req;
        logic [EXPERT_W-1:0] expert;
        logic [COLUMN_W-1:0] column;
        logic [SAMPLE_W-1:0] sample;
        logic                row_end;
    } sq_item_t;

    // one readout result
    typedef struct packed {
        logic [SUM_W-1:0] mean_square;
        logic [CNT_W-1:0] row_count;
        logic             no_samples;
    } mean_result_t;

    // own copy of the sum store, the row counts and the limits; readouts queue
    // their predicted mean in order of acceptance
    class importance_scoreboard;
        logic [SUM_W-1:0]  cell_sum [int];
        logic [CNT_W-1:0]  expert_rows [N_EXPERTS];
        logic [NEXP_W-1:0] num_experts;
        logic [NCOL_W-1:0] num_columns;
        mean_result_t      pending_means [$];
        int unsigned       errors;
        int unsigned       items_seen;
        int unsigned       results_seen;

        function new();
            foreach (expert_rows[i]) expert_rows[i] = '0;
            num_experts  = NUM_EXPERTS_RST;
            num_columns  = NUM_COLUMNS_RST;
            errors       = 0;
            items_seen   = 0;
            results_seen = 0;
        endfunction

        function int unsigned expert_limit();
            return (num_experts < N_EXPERTS) ? num_experts : N_EXPERTS;
        endfunction

        function int unsigned column_limit();
            return (num_columns < N_COLUMNS) ? num_columns : N_COLUMNS;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_NUM_EXPERTS: num_experts = value[NEXP_W-1:0];
                REG_NUM_COLUMNS: num_columns = value[NCOL_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [SUM_W-1:0] sum_of(int key);
            return cell_sum.exists(key) ? cell_sum[key] : '0;
        endfunction

        function void note_item(sq_item_t it);
            int               key;
            bit               in_ex;
            bit               in_col;
            logic [SUM_W-1:0] sq;
            logic [SUM_W:0]   total;
            mean_result_t     res;
            key    = int'(it.expert) * N_COLUMNS + int'(it.column);
            in_ex  = it.expert < expert_limit();
            in_col = it.column < column_limit();
            items_seen++;
            if (it.req == REQ_ACCUMULATE) begin
                if (!in_ex) begin
                    return;
                end
                if (in_col) begin
                    // magnitude of the q8.8 sample, squared into q16.16
                    if (it.sample[SAMPLE_W-1]) begin
                        sq = {{(SUM_W-SAMPLE_W){1'b0}}, ~it.sample} + 1'b1;
                    end else begin
                        sq = {{(SUM_W-SAMPLE_W){1'b0}}, it.sample};
                    end
                    sq    = sq * sq;
                    total = {1'b0, sum_of(key)} + {1'b0, sq};
                    cell_sum[key] = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
                end
                if (it.row_end && expert_rows[it.expert] != {CNT_W{1'b1}}) begin
                    expert_rows[it.expert]++;
                end
                return;
            end
            if (!in_ex || !in_col || expert_rows[it.expert] == '0) begin
                res = '{mean_square: '0, row_count: '0, no_samples: 1'b1};
            end else begin
                res.mean_square = sum_of(key) / expert_rows[it.expert];
                res.row_count   = expert_rows[it.expert];
                res.no_samples  = 1'b0;
            end
            pending_means.push_back(res);
        endfunction

        function void check_result(mean_result_t got);
            mean_result_t want;
            results_seen++;
            if (pending_means.size() == 0) begin
                errors++;
                $display("%0t: result with none outstanding: mean_square %0d row_count %0d no_samples %0b",
                         $time, got.mean_square, got.row_count, got.no_samples);
                return;
            end
            want = pending_means.pop_front();
            if (got.mean_square !== want.mean_square) begin
                errors++;
                $display("%0t: mean_square expected %0d actual %0d",
                         $time, want.mean_square, got.mean_square);
            end
            if (got.row_count !== want.row_count) begin
                errors++;
                $display("%0t: row_count expected %0d actual %0d",
                         $time, want.row_count, got.row_count);
            end
            if (got.no_samples !== want.no_samples) begin
                errors++;
                $display("%0t: no_samples expected %0b actual %0b",
                         $time, want.no_samples, got.no_samples);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // expert, column, sample, zero padding
    logic                  s_tuser;   // req_type
    logic                  s_tlast;   // row_end
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // mean_square, row_count
    logic                  m_tuser;   // no_samples
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    importance_scoreboard sb = new();

    // chance in percent that a stall burst starts, per side; zero gives a clean stretch
    int unsigned s_idle_pct = 0;
    int unsigned m_idle_pct = 0;

    per_expert_sum_of_squares_accumulator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // present one item, hold it until accepted, then maybe leave a short gap
    task automatic send_item(logic req, logic [EXPERT_W-1:0] ex, logic [COLUMN_W-1:0] col,
                             logic [SAMPLE_W-1:0] smp, logic last);
        sq_item_t it;
        it = '{req: req, expert: ex, column: col, sample: smp, row_end: last};
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tlast  <= last;
        s_tdata  <= {{PAD_W{1'b0}}, smp, col, ex};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(it);
        if ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // stop sending, let every readout come back, then let the pipeline drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending_means.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // only called while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge aclk);
    endtask

    // mostly experts in use, now and then any id so the ignore path is hit
    function automatic logic [EXPERT_W-1:0] pick_expert();
        int unsigned lim;
        lim = sb.expert_limit();
        if (lim == 0 || $urandom_range(0, 7) == 0) begin
            return EXPERT_W'($urandom);
        end
        return EXPERT_W'($urandom_range(0, lim - 1));
    endfunction

    // a few hot columns so cells build up sums, some spread, some out of range
    function automatic logic [COLUMN_W-1:0] pick_column();
        int unsigned lim;
        lim = sb.column_limit();
        if (lim == 0 || $urandom_range(0, 7) == 0) begin
            return COLUMN_W'($urandom);
        end
        if ($urandom_range(0, 3) == 0) begin
            return COLUMN_W'($urandom_range(0, lim - 1));
        end
        return COLUMN_W'($urandom_range(0, ((lim < 6) ? lim : 6) - 1));
    endfunction

    // extremes of the q8.8 range show up often, otherwise any bit pattern
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // rows of samples for one expert, readouts of the cells they touch, and noise
    task automatic run_phase(int unsigned n_items);
        int unsigned         sent;
        int unsigned         row_len;
        int unsigned         pick;
        logic [EXPERT_W-1:0] ex;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                ex      = pick_expert();
                row_len = $urandom_range(1, 6);
                for (int unsigned k = 0; k < row_len; k++) begin
                    send_item(REQ_ACCUMULATE, ex, pick_column(), pick_sample(),
                              (k == row_len - 1) ? 1'b1 : ($urandom_range(0, 15) == 0));
                end
                sent += row_len;
            end else if (pick < 9) begin
                // sample and row_end carry junk, the block must ignore them
                send_item(REQ_READOUT, pick_expert(), pick_column(), SAMPLE_W'($urandom),
                          1'($urandom_range(0, 1)));
                sent++;
            end else begin
                send_item(1'($urandom_range(0, 1)), EXPERT_W'($urandom), COLUMN_W'($urandom),
                          SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // result side: check every accepted result, stall in random bursts
    initial begin : result_sink
        int unsigned  hold;
        mean_result_t got;
        hold = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.mean_square = m_tdata[SUM_W-1:0];
                got.row_count   = m_tdata[SUM_W +: CNT_W];
                got.no_samples  = m_tuser;
                sb.check_result(got);
            end
            if (hold == 0 && $urandom_range(0, 99) < m_idle_pct) begin
                hold = $urandom_range(1, 4);
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int unsigned ne;
        int unsigned nc;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_ACCUMULATE;
        s_tlast   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_NUM_EXPERTS;
        cfg_wdata <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        // s_tready stays low through the clearing sweep, send_item just waits

        // directed part, reset limits of 16 experts and 1024 columns
        m_idle_pct = 20;
        send_item(REQ_READOUT,    4'd0,  10'd0,    16'h0000, 1'b0);  // empty store
        send_item(REQ_ACCUMULATE, 4'd15, 10'd1023, 16'h8000, 1'b1);  // largest square
        send_item(REQ_ACCUMULATE, 4'd15, 10'd1023, 16'h7fff, 1'b0);
        send_item(REQ_ACCUMULATE, 4'd15, 10'd1023, 16'hffff, 1'b0);
        send_item(REQ_ACCUMULATE, 4'd15, 10'd1023, 16'h0001, 1'b1);
        send_item(REQ_READOUT,    4'd15, 10'd1023, 16'hffff, 1'b1);  // junk fields ignored
        send_item(REQ_ACCUMULATE, 4'd0,  10'd0,    16'h0000, 1'b1);  // zero sample, one row
        send_item(REQ_READOUT,    4'd0,  10'd0,    16'h5a5a, 1'b0);
        send_item(REQ_ACCUMULATE, 4'd0,  10'd1,    16'h1234, 1'b0);
        send_item(REQ_READOUT,    4'd0,  10'd1,    16'h0000, 1'b0);
        settle();

        // narrow limits: column out of range still counts the row, expert out drops all
        write_reg(REG_NUM_EXPERTS, 11'd2);
        write_reg(REG_NUM_COLUMNS, 11'd4);
        send_item(REQ_ACCUMULATE, 4'd1,  10'd7,    16'h4000, 1'b1);
        send_item(REQ_ACCUMULATE, 4'd5,  10'd0,    16'h4000, 1'b1);
        send_item(REQ_READOUT,    4'd1,  10'd0,    16'h0000, 1'b0);
        send_item(REQ_READOUT,    4'd1,  10'd7,    16'h0000, 1'b0);
        send_item(REQ_READOUT,    4'd5,  10'd0,    16'h0000, 1'b0);
        send_item(REQ_READOUT,    4'd15, 10'd1023, 16'h0000, 1'b0);
        settle();

        // zero expert limit: nothing is in range
        write_reg(REG_NUM_EXPERTS, 11'd0);
        send_item(REQ_ACCUMULATE, 4'd0,  10'd0,    16'h7fff, 1'b1);
        send_item(REQ_READOUT,    4'd0,  10'd0,    16'h0000, 1'b0);
        settle();

        // limits above the maximum clamp, and the store survived the writes;
        // upper bits of the expert write are dropped by the register width
        write_reg(REG_NUM_EXPERTS, 11'h7ff);
        write_reg(REG_NUM_COLUMNS, 11'h7ff);
        send_item(REQ_READOUT,    4'd15, 10'd1023, 16'h0000, 1'b0);
        send_item(REQ_READOUT,    4'd0,  10'd0,    16'h0000, 1'b0);
        settle();

        // zero column limit: rows still counted, every readout out of range
        write_reg(REG_NUM_COLUMNS, 11'd0);
        send_item(REQ_ACCUMULATE, 4'd3,  10'd0,    16'h8000, 1'b1);
        send_item(REQ_READOUT,    4'd3,  10'd0,    16'h0000, 1'b0);
        settle();

        // random phases, each under its own limits and stall mix; the last is stall free
        for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin ne = 16; nc = 1024; end
                1: begin ne = 1;  nc = 1;    end
                2: begin ne = 4;  nc = 8;    end
                3: begin ne = 31; nc = 2047; end
                4: begin ne = 9;  nc = 37;   end
                5: begin ne = $urandom_range(1, 16); nc = $urandom_range(1, 1024); end
                6: begin ne = 16; nc = 1000; end
                default: begin ne = 16; nc = 16; end
            endcase
            write_reg(REG_NUM_EXPERTS, CFG_DATA_W'(ne));
            write_reg(REG_NUM_COLUMNS, CFG_DATA_W'(nc));
            if (ph == N_PHASES - 1) begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end else begin
                s_idle_pct = $urandom_range(0, 2) * 15;
                m_idle_pct = $urandom_range(0, 2) * 15;
            end
            run_phase(PHASE_ITEMS);
            settle();
        end

        $display("covered %0d input items and %0d readout results over %0d random limit settings",
                 sb.items_seen, sb.results_seen, N_PHASES);
        $display("directed part hit sample extremes, zero and clamped limits and out of range cells");
        if (sb.errors == 0 && sb.pending_means.size() == 0) begin
            $display("PASS per_expert_sum_of_squares_accumulator");
        end else begin
            $display("FAIL per_expert_sum_of_squares_accumulator");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run including the clearing sweep
    initial begin
        #3000000;
        $display("%0t: timed out with %0d results outstanding", $time, sb.pending_means.size());
        $display("FAIL per_expert_sum_of_squares_accumulator");
        $finish;
    end

endmodule
